/* hdl/grsfe_pkg.sv */
// Shared constants and the ring-store control bundle for the Glauber spin-flip engine.
// No dependencies; used by grsfe_rings and the top level.
package grsfe_pkg;

	localparam int SPINS     = 256;
	localparam int MAX_RANGE = 32;

	// fixed field widths
	localparam int SITE_W  = 8;
	localparam int RANGE_W = 6;
	localparam int FIELD_W = 9;
	localparam int WALL_W  = 9;
	localparam int OPC_W   = 2;

	// ring addressing and counting
	localparam int ADDR_W = $clog2(SPINS);
	localparam int CNT_W  = $clog2(SPINS + 1);
	localparam int ACC_W  = CNT_W + 1;
	localparam int PROD_W = (ACC_W + 1 > FIELD_W + 1) ? ACC_W + 1 : FIELD_W + 1;

	localparam int FIELD_MAX = (1 << (FIELD_W - 1)) - 1;
	localparam int FIELD_MIN = -(1 << (FIELD_W - 1));
	localparam int WALL_MAX  = (1 << WALL_W) - 1;

	typedef struct packed {
		logic              c_we;
		logic [ADDR_W-1:0] c_waddr;
		logic              c_wdata;
		logic              c_re;
		logic [ADDR_W-1:0] c_raddr;
		logic              w_we;
		logic [ADDR_W-1:0] w_waddr;
		logic              w_wdata;
		logic              w_re;
		logic [ADDR_W-1:0] w_raddr;
	} ring_ctl_t;

endpackage

/* hdl/grsfe_rings.sv */
// Committed and working spin rings, one bit per site, one write and one read port each.
// Depends on grsfe_pkg for the ring depth and the control bundle.
module grsfe_rings (
	input  logic                  clk,
	input  grsfe_pkg::ring_ctl_t  ctl,
	output logic                  c_rdata_q,
	output logic                  w_rdata_q
);

	logic committed_mem [grsfe_pkg::SPINS];
	logic working_mem   [grsfe_pkg::SPINS];

	always_ff @(posedge clk) begin
		if (ctl.c_we) begin
			committed_mem[ctl.c_waddr] <= ctl.c_wdata;
		end
		if (ctl.c_re) begin
			c_rdata_q <= committed_mem[ctl.c_raddr];
		end
	end

	// read data holds between reads
	always_ff @(posedge clk) begin
		if (ctl.w_we) begin
			working_mem[ctl.w_waddr] <= ctl.w_wdata;
		end
		if (ctl.w_re) begin
			w_rdata_q <= working_mem[ctl.w_raddr];
		end
	end

endmodule

/* hdl/glauber_ring_spin_flip_engine_top.sv */
// Top level of the zero-temperature Glauber spin-flip engine: APB register, stream
// handshake, sequencer and the shared site counter. Depends on grsfe_pkg and grsfe_rings.
//
// Usage:
//   Input stream: tuser carries the opcode (load, flip attempt, end of sweep), tdata the
//   sites and the spin. Every transfer gives exactly one result transfer on the output
//   stream (flipped, local field, wall count).
//   Items are handled one at a time: s_axis_tready is high only while the sequencer idles,
//   so the next item is taken only once the sequencer is back in idle.
//   Load: the spin is written to site_a in both rings before the result is given.
//   Flip attempt: the committed ring is read one site a cycle through its single read port,
//   summed by one counter.
//   End of sweep: every site is copied from the working to the committed ring and
//   compared with its predecessor, one site a cycle.
//   After reset both rings are cleared by a pass over every site during which no item
//   is taken; coupling_range resets to 1 and may be written meanwhile.
//   A finished result waits in the output register; a new item is taken while it waits,
//   but the next result is held back until the receiver has taken the previous one.
//   coupling_range is written through APB at byte address 0; values above the maximum
//   range are stored as the maximum.
module glauber_ring_spin_flip_engine_top (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [7:0] site_a, [15:8] site_b, [16] spin_value
	input  logic [1:0]  s_axis_tuser,   // [1:0] opcode

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [0] flipped, [9:1] local_field, [18:10] wall_count
);

	localparam int ADDR_W = grsfe_pkg::ADDR_W;
	localparam int CNT_W  = grsfe_pkg::CNT_W;
	localparam int ACC_W  = grsfe_pkg::ACC_W;
	localparam int PROD_W = grsfe_pkg::PROD_W;

	localparam logic REG_COUPLING_RANGE = 1'b0;

	typedef enum logic [grsfe_pkg::OPC_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_ATTEMPT = 2'd1,
		OP_SWEEP   = 2'd2
	} op_t;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_LOAD  = 8'b0000_0100,
		ST_SETUP = 8'b0000_1000,
		ST_FIELD = 8'b0001_0000,
		ST_FLIP  = 8'b0010_0000,
		ST_SWEEP = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t                              state_q;
	logic [grsfe_pkg::RANGE_W-1:0]       range_q;
	logic [grsfe_pkg::SITE_W-1:0]        a_q;
	logic [grsfe_pkg::SITE_W-1:0]        b_q;
	logic                                s_q;
	logic                                in_range_q;
	logic                                self_q;
	logic                                center_q;
	logic signed [ACC_W-1:0]             acc_q;
	logic [ADDR_W-1:0]                   idx_q;
	logic [CNT_W-1:0]                    left_q;
	logic                                rd_v_q;
	logic [ADDR_W-1:0]                   rd_site_q;
	logic                                first_q;
	logic                                prev_q;
	logic [CNT_W-1:0]                    walls_q;
	logic                                res_flip_q;
	logic [grsfe_pkg::FIELD_W-1:0]       res_field_q;
	logic [grsfe_pkg::WALL_W-1:0]        res_walls_q;
	logic                                m_valid_q;
	logic                                m_flip_q;
	logic [grsfe_pkg::FIELD_W-1:0]       m_field_q;
	logic [grsfe_pkg::WALL_W-1:0]        m_walls_q;

	grsfe_pkg::ring_ctl_t                ring_ctl;
	logic                                c_rdata;
	logic                                w_rdata;

	logic                                cfg_wr;
	logic [grsfe_pkg::RANGE_W-1:0]       cfg_val;
	op_t                                 s_op;
	logic [ADDR_W-1:0]                   a_ad;
	logic [ADDR_W-1:0]                   b_ad;
	logic                                a_ok;
	logic                                b_ok;
	logic [ADDR_W-1:0]                   diff;
	logic [CNT_W-1:0]                    alt;
	logic [CNT_W-1:0]                    site_gap;
	logic                                in_range;
	logic                                self_in;
	logic                                window_full;
	logic [31:0]                         start_w;
	logic [ADDR_W-1:0]                   start_ad;
	logic [CNT_W-1:0]                    count;
	logic [ADDR_W-1:0]                   idx_next;
	logic                                issue;
	logic                                walk_end;
	logic signed [ACC_W-1:0]             step;
	logic signed [PROD_W-1:0]            dbl;
	logic signed [PROD_W-1:0]            field_raw;
	logic                                field_pos;
	logic [grsfe_pkg::FIELD_W-1:0]       field_sat;
	logic                                flip_ok;
	logic [CNT_W-1:0]                    walls_tot;
	logic [grsfe_pkg::WALL_W-1:0]        walls_sat;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_COUPLING_RANGE);
	assign cfg_val = pwdata[grsfe_pkg::RANGE_W-1:0];
	assign prdata  = (paddr[2] == REG_COUPLING_RANGE) ? 32'(range_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= grsfe_pkg::RANGE_W'(1);
		end else if (cfg_wr) begin
			if (32'(cfg_val) > 32'(grsfe_pkg::MAX_RANGE)) begin
				range_q <= grsfe_pkg::RANGE_W'(grsfe_pkg::MAX_RANGE);
			end else begin
				range_q <= cfg_val;
			end
		end
	end

	// site arithmetic
	assign s_op  = op_t'(s_axis_tuser);
	assign a_ad  = ADDR_W'(a_q);
	assign b_ad  = ADDR_W'(b_q);
	assign a_ok  = 32'(a_q) < 32'(grsfe_pkg::SPINS);
	assign b_ok  = 32'(b_q) < 32'(grsfe_pkg::SPINS);
	assign diff  = (a_ad >= b_ad) ? (a_ad - b_ad) : (b_ad - a_ad);
	assign alt   = CNT_W'(grsfe_pkg::SPINS) - CNT_W'(diff);
	assign site_gap = (CNT_W'(diff) < alt) ? CNT_W'(diff) : alt;
	assign in_range    = b_ok && (32'(site_gap) <= 32'(range_q));
	assign self_in     = 32'(range_q) >= 32'(grsfe_pkg::SPINS);
	// window of 2r+1 sites covers the whole ring: walk it from site zero
	assign window_full = 32'({range_q, 1'b1}) >= 32'(grsfe_pkg::SPINS);
	assign start_w     = (32'(a_ad) >= 32'(range_q))
		? (32'(a_ad) - 32'(range_q))
		: (32'(a_ad) + 32'(grsfe_pkg::SPINS) - 32'(range_q));
	assign start_ad    = window_full ? '0 : ADDR_W'(start_w);
	assign count       = window_full ? CNT_W'(grsfe_pkg::SPINS) : CNT_W'({range_q, 1'b1});
	assign idx_next    = (idx_q == ADDR_W'(grsfe_pkg::SPINS - 1)) ? '0 : idx_q + ADDR_W'(1);
	assign issue       = (left_q != '0);
	assign walk_end    = !issue && !rd_v_q;

	assign step      = c_rdata ? ACC_W'(1) : -ACC_W'(1);
	assign dbl       = PROD_W'(acc_q) <<< 1;
	assign field_raw = center_q ? dbl : -dbl;
	assign field_pos = !field_raw[PROD_W-1] && (field_raw != '0);
	assign flip_ok   = in_range_q && !field_pos;

	always_comb begin
		if (field_raw > PROD_W'(grsfe_pkg::FIELD_MAX)) begin
			field_sat = grsfe_pkg::FIELD_W'(grsfe_pkg::FIELD_MAX);
		end else if (field_raw < PROD_W'(grsfe_pkg::FIELD_MIN)) begin
			field_sat = grsfe_pkg::FIELD_W'(grsfe_pkg::FIELD_MIN);
		end else begin
			field_sat = grsfe_pkg::FIELD_W'(field_raw);
		end
	end

	// close the ring: last site against the first
	assign walls_tot = walls_q + CNT_W'(prev_q != first_q);
	assign walls_sat = (32'(walls_tot) > 32'(grsfe_pkg::WALL_MAX))
		? grsfe_pkg::WALL_W'(grsfe_pkg::WALL_MAX) : grsfe_pkg::WALL_W'(walls_tot);

	// ring port control
	always_comb begin
		ring_ctl = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ring_ctl.c_we    = 1'b1;
				ring_ctl.c_waddr = idx_q;
				ring_ctl.w_we    = 1'b1;
				ring_ctl.w_waddr = idx_q;
			end
			ST_LOAD: begin
				ring_ctl.c_we    = a_ok;
				ring_ctl.c_waddr = a_ad;
				ring_ctl.c_wdata = s_q;
				ring_ctl.w_we    = a_ok;
				ring_ctl.w_waddr = a_ad;
				ring_ctl.w_wdata = s_q;
			end
			ST_SETUP: begin
				ring_ctl.w_re    = 1'b1;
				ring_ctl.w_raddr = a_ad;
			end
			ST_FIELD: begin
				ring_ctl.c_re    = issue;
				ring_ctl.c_raddr = idx_q;
			end
			ST_FLIP: begin
				ring_ctl.w_we    = flip_ok;
				ring_ctl.w_waddr = a_ad;
				ring_ctl.w_wdata = !w_rdata;
			end
			ST_SWEEP: begin
				ring_ctl.w_re    = issue;
				ring_ctl.w_raddr = idx_q;
				ring_ctl.c_we    = rd_v_q;
				ring_ctl.c_waddr = rd_site_q;
				ring_ctl.c_wdata = w_rdata;
			end
			default: begin
			end
		endcase
	end

	grsfe_rings u_rings (
		.clk       (clk),
		.ctl       (ring_ctl),
		.c_rdata_q (c_rdata),
		.w_rdata_q (w_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			a_q         <= '0;
			b_q         <= '0;
			s_q         <= 1'b0;
			in_range_q  <= 1'b0;
			self_q      <= 1'b0;
			center_q    <= 1'b0;
			acc_q       <= '0;
			idx_q       <= '0;
			left_q      <= '0;
			rd_v_q      <= 1'b0;
			rd_site_q   <= '0;
			first_q     <= 1'b0;
			prev_q      <= 1'b0;
			walls_q     <= '0;
			res_flip_q  <= 1'b0;
			res_field_q <= '0;
			res_walls_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_next;
					if (idx_q == ADDR_W'(grsfe_pkg::SPINS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						a_q         <= s_axis_tdata[7:0];
						b_q         <= s_axis_tdata[15:8];
						s_q         <= s_axis_tdata[16];
						res_flip_q  <= 1'b0;
						res_field_q <= '0;
						res_walls_q <= '0;
						unique case (s_op)
							OP_LOAD:    state_q <= ST_LOAD;
							OP_ATTEMPT: state_q <= ST_SETUP;
							OP_SWEEP: begin
								idx_q   <= '0;
								left_q  <= CNT_W'(grsfe_pkg::SPINS);
								walls_q <= '0;
								rd_v_q  <= 1'b0;
								state_q <= ST_SWEEP;
							end
							default:    state_q <= ST_DONE;
						endcase
					end
				end
				ST_LOAD: begin
					state_q <= ST_DONE;
				end
				ST_SETUP: begin
					if (!a_ok) begin
						state_q <= ST_DONE;
					end else begin
						in_range_q <= in_range;
						self_q     <= self_in;
						idx_q      <= start_ad;
						left_q     <= count;
						acc_q      <= '0;
						rd_v_q     <= 1'b0;
						state_q    <= ST_FIELD;
					end
				end
				ST_FIELD: begin
					rd_v_q <= issue;
					if (issue) begin
						idx_q     <= idx_next;
						left_q    <= left_q - CNT_W'(1);
						rd_site_q <= idx_q;
					end
					if (rd_v_q) begin
						if (rd_site_q == a_ad) begin
							center_q <= c_rdata;
						end
						if ((rd_site_q != a_ad) || self_q) begin
							acc_q <= acc_q + step;
						end
					end
					if (walk_end) begin
						state_q <= ST_FLIP;
					end
				end
				ST_FLIP: begin
					res_flip_q  <= flip_ok;
					res_field_q <= field_sat;
					state_q     <= ST_DONE;
				end
				ST_SWEEP: begin
					rd_v_q <= issue;
					if (issue) begin
						idx_q     <= idx_next;
						left_q    <= left_q - CNT_W'(1);
						rd_site_q <= idx_q;
					end
					if (rd_v_q) begin
						prev_q <= w_rdata;
						if (rd_site_q == '0) begin
							first_q <= w_rdata;
						end else if (w_rdata != prev_q) begin
							walls_q <= walls_q + CNT_W'(1);
						end
					end
					if (walk_end) begin
						res_walls_q <= walls_sat;
						state_q     <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// output register: hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_flip_q  <= 1'b0;
			m_field_q <= '0;
			m_walls_q <= '0;
		end else if ((state_q == ST_DONE) && (!m_valid_q || m_axis_tready)) begin
			m_valid_q <= 1'b1;
			m_flip_q  <= res_flip_q;
			m_field_q <= res_field_q;
			m_walls_q <= res_walls_q;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'd0, m_walls_q, m_field_q, m_flip_q};

	// one item at a time: after a transfer in, the input side closes
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while an item is in work");

	// the committed ring is never read and written in the same cycle
	a_ring_port: assert property (@(posedge clk) disable iff (!arst_n)
		ring_ctl.c_re |-> !ring_ctl.c_we)
		else $error("committed ring read and written together");

	// a result appears only on leaving the done state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	// a flip write is always followed by the done state with a flipped result
	a_flip_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLIP) && ring_ctl.w_we |=> (state_q == ST_DONE) && res_flip_q)
		else $error("flip written without a flipped result");

endmodule
